// ----- rtl/core/stack_machine_executor_defines.svh -----
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the synchronous reset is low.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// same-cycle implication
`define SME_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SME_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sme_pkg.sv -----
// ----------------------------------------------------------------------------
// Stack machine executor package
// Sizes, op and status codes, item structs and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_W      = 32;
    localparam int IMM_W       = 32;
    localparam int VAL_W       = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W       = $clog2(DATA_W);

    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_POP  = 3'd5;
    localparam logic [2:0] OP_HALT = 3'd6;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_HALTED = 3'd4;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [IMM_W-1:0] immediate;
    } sme_in_t;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [VAL_W-1:0] value;
        logic [DEPTH_W-1:0]      depth;
        logic                    halted;
    } sme_out_t;

    typedef enum logic [1:0] {
        FN_ADD,
        FN_SUB,
        FN_MUL,
        FN_DIV
    } alu_fn_t;

    typedef struct packed {
        logic    start;
        alu_fn_t fn;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_DIVIDE,
        ALU_FIX,
        ALU_DONE
    } alu_state_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_WAIT,
        SEQ_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/stack_machine_executor.sv -----
// ----------------------------------------------------------------------------
// Stack machine executor
// Runs one stack instruction per item against a 256-entry stack.
// ----------------------------------------------------------------------------
//  channel   ports                    payload
//  input     s_valid s_ready s_data   sme_in_t  (op, immediate)
//  result    m_valid m_ready m_data   sme_out_t (status, value, depth, halted)
//
//  Push, pop, halt, errors and refusals skip the arithmetic unit; add, sub,
//  mul and divide use the shared unit, which resolves one quotient bit per cycle.
//  The top entry lives in a register; the stack RAM read of the entry below
//  it is registered. Reset empties the stack and clears the halted flag;
//  RAM contents are kept. A new item is taken while a result waits;
//  m_ready low stalls only the finish step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_machine_executor_defines.svh"

module stack_machine_executor
    import sme_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sme_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sme_out_t      m_data
);

    seq_state_t              state_reg, state_next;
    logic [2:0]              op_reg;
    logic signed [IMM_W-1:0] imm_reg;
    logic [DEPTH_W-1:0]      depth_reg;
    logic [DATA_W-1:0]       top_reg;
    logic                    halted_reg;
    logic [DATA_W-1:0]       rd_data_reg;
    logic [2:0]              res_status_reg;
    logic                    res_pop_reg;
    logic [DATA_W-1:0]       res_popval_reg;
    logic                    m_valid_reg;
    sme_out_t                m_data_reg;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic [PTR_W-1:0] rd_addr, wr_addr;
    logic             accept, out_free;
    logic             is_bin, full, has_two, empty;
    logic             push_ok, pop_ok, bin_ok;
    logic [2:0]       exec_status;
    logic             mem_we;
    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;
    logic [DATA_W-1:0] out_value;

    assign rd_addr  = PTR_W'(depth_reg - DEPTH_W'(2));
    assign wr_addr  = PTR_W'(depth_reg - DEPTH_W'(1));
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // decode of the item held in EXEC
    always_comb begin
        is_bin  = (op_reg == OP_ADD) || (op_reg == OP_SUB) ||
                  (op_reg == OP_MUL) || (op_reg == OP_DIV);
        full    = (depth_reg >= DEPTH_W'(STACK_DEPTH));
        empty   = (depth_reg == '0);
        has_two = (depth_reg >= DEPTH_W'(2));
        push_ok = !halted_reg && (op_reg == OP_PUSH) && !full;
        pop_ok  = !halted_reg && (op_reg == OP_POP) && !empty;
        bin_ok  = !halted_reg && is_bin && has_two &&
                  !((op_reg == OP_DIV) && (top_reg == '0));
        if (halted_reg) begin
            exec_status = ST_HALTED;
        end else if ((op_reg == OP_PUSH) && full) begin
            exec_status = ST_OVER;
        end else if ((is_bin && !has_two) || ((op_reg == OP_POP) && empty)) begin
            exec_status = ST_UNDER;
        end else if ((op_reg == OP_DIV) && (top_reg == '0)) begin
            exec_status = ST_DIVZ;
        end else begin
            exec_status = ST_OK;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC:   state_next = bin_ok ? SEQ_WAIT : SEQ_FINISH;
            SEQ_WAIT: begin
                if (alu_rsp.done) begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH: begin
                if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            default:    state_next = SEQ_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready       = (state_reg == SEQ_IDLE);
        mem_we        = (state_reg == SEQ_EXEC) && push_ok && !empty;
        alu_req.start = (state_reg == SEQ_EXEC) && bin_ok;
        case (op_reg)
            OP_ADD:  alu_req.fn = FN_ADD;
            OP_SUB:  alu_req.fn = FN_SUB;
            OP_MUL:  alu_req.fn = FN_MUL;
            default: alu_req.fn = FN_DIV;
        endcase
        if (res_pop_reg) begin
            out_value = res_popval_reg;
        end else if (empty) begin
            out_value = '0;
        end else begin
            out_value = top_reg;
        end
    end

    sme_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (rd_data_reg),
        .opb     (top_reg),
        .rsp     (alu_rsp)
    );

    // stack RAM: entries below the top
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= top_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            depth_reg   <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == SEQ_EXEC) begin
                if (push_ok) begin
                    depth_reg <= depth_reg + DEPTH_W'(1);
                end else if (pop_ok) begin
                    depth_reg <= depth_reg - DEPTH_W'(1);
                end
                if (!halted_reg && (op_reg == OP_HALT)) begin
                    halted_reg <= 1'b1;
                end
            end
            if ((state_reg == SEQ_WAIT) && alu_rsp.done) begin
                depth_reg <= depth_reg - DEPTH_W'(1);
            end
            if ((state_reg == SEQ_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            op_reg  <= s_data.op;
            imm_reg <= s_data.immediate;
        end
        if (state_reg == SEQ_EXEC) begin
            res_status_reg <= exec_status;
            res_pop_reg    <= pop_ok;
            res_popval_reg <= top_reg;
            if (push_ok) begin
                top_reg <= DATA_W'(imm_reg);
            end else if (pop_ok) begin
                // refill from the entry below; meaningless when emptied
                top_reg <= rd_data_reg;
            end
        end
        if ((state_reg == SEQ_WAIT) && alu_rsp.done) begin
            top_reg <= alu_rsp.result;
        end
        if ((state_reg == SEQ_FINISH) && out_free) begin
            m_data_reg.status <= res_status_reg;
            m_data_reg.value  <= signed'(VAL_W'(out_value));
            m_data_reg.depth  <= depth_reg;
            m_data_reg.halted <= halted_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SME_ASSERT_NOW(a_depth_range, aclk, aresetn, 1'b1, depth_reg <= DEPTH_W'(STACK_DEPTH), "stack depth beyond capacity")
    `SME_ASSERT_NEXT(a_halt_sticky, aclk, aresetn, halted_reg, halted_reg, "halted flag cleared without reset")
    `SME_ASSERT_NOW(a_exec_after_accept, aclk, aresetn, state_reg == SEQ_EXEC, $past(accept), "execute step without an accepted item")

endmodule

`default_nettype wire

// ----- rtl/core/sme_alu.sv -----
// ----------------------------------------------------------------------------
// Stack machine shared arithmetic unit
// Add, subtract and multiply are registered into the result; signed divide by
// restoring shift-subtract, one quotient bit per cycle, then a sign fix-up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_machine_executor_defines.svh"

module sme_alu
    import sme_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire alu_req_t          req,
    input  wire logic [DATA_W-1:0] opa,
    input  wire logic [DATA_W-1:0] opb,
    output alu_rsp_t               rsp
);

    alu_state_t          state_reg, state_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [DATA_W-1:0]   quo_reg, quo_next;
    logic [DATA_W-1:0]   dvs_reg, dvs_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [DATA_W-1:0]   res_reg, res_next;

    logic [DATA_W-1:0]   mag_a, mag_b;
    logic [DATA_W-1:0]   product;
    logic [DATA_W:0]     shifted, trial;

    assign mag_a   = opa[DATA_W-1] ? (~opa + DATA_W'(1)) : opa;
    assign mag_b   = opb[DATA_W-1] ? (~opb + DATA_W'(1)) : opb;
    // only the low word is kept, wrapping like the other ops
    assign product = opa * opb;
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ALU_IDLE: begin
                if (req.start) begin
                    state_next = (req.fn == FN_DIV) ? ALU_DIVIDE : ALU_DONE;
                end
            end
            ALU_DIVIDE: begin
                if (cnt_reg == '0) begin
                    state_next = ALU_FIX;
                end
            end
            ALU_FIX:  state_next = ALU_DONE;
            ALU_DONE: state_next = ALU_IDLE;
            default:  state_next = ALU_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        res_next = res_reg;
        case (state_reg)
            ALU_IDLE: begin
                if (req.start) begin
                    case (req.fn)
                        FN_ADD:  res_next = opa + opb;
                        FN_SUB:  res_next = opa - opb;
                        FN_MUL:  res_next = product;
                        default: begin
                            rem_next = '0;
                            quo_next = mag_a;
                            dvs_next = mag_b;
                            cnt_next = CNT_W'(DATA_W - 1);
                            neg_next = opa[DATA_W-1] ^ opb[DATA_W-1];
                        end
                    endcase
                end
            end
            ALU_DIVIDE: begin
                if (!trial[DATA_W]) begin
                    rem_next = trial[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
            end
            ALU_FIX: begin
                // most negative over minus one wraps back naturally here
                res_next = neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        rsp.done   = (state_reg == ALU_DONE);
        rsp.result = res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ALU_IDLE;
        end else begin
            state_reg <= state_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    `SME_ASSERT_NOW(a_start_idle, aclk, aresetn, req.start, state_reg == ALU_IDLE, "alu started while busy")
    `SME_ASSERT_NEXT(a_done_pulse, aclk, aresetn, rsp.done, !rsp.done, "alu done held over two cycles")
    `SME_ASSERT_NEXT(a_div_end, aclk, aresetn, (state_reg == ALU_DIVIDE) && (cnt_reg == '0), state_reg == ALU_FIX, "divide did not finish after last bit")

endmodule

`default_nettype wire

// ----- tb/tb_stack_machine_executor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Sends instruction items under random gaps and result stalls. A shadow stack
// predicts every result when its item is accepted. Results are checked in
// order, field by field, against the predictions.
// ----------------------------------------------------------------------------

module tb_stack_machine_executor;
    import sme_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_REPORTS  = 10;

    localparam logic [DATA_W-1:0] MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_WORD = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // op code seven is not assigned in the package
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sme_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sme_out_t m_data;

    stack_machine_executor DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // shadow machine state
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned       shadow_depth  = 0;
    bit                shadow_halted = 1'b0;

    sme_out_t    pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned stall_left     = 0;
    bit          idle_on        = 1'b0;

    always #(CLK_HALF) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MIN_WORD;
            2: return MAX_WORD;
            3: return ALL_ONES;
            4: return $urandom_range(0, 15);
            5: return ~$urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // executes one instruction on the shadow stack, returns the expected result
    function automatic sme_out_t execute_op(sme_in_t item);
        sme_out_t          res;
        logic [DATA_W-1:0] top_w;
        logic [DATA_W-1:0] next_w;
        logic [DATA_W-1:0] result_w;
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quot;
        bit                popped;
        res      = '0;
        res.status = ST_OK;
        popped   = 1'b0;
        result_w = '0;
        if (shadow_halted) begin
            res.status = ST_HALTED;
        end else begin
            case (item.op)
                OP_PUSH: begin
                    if (shadow_depth >= STACK_DEPTH) begin
                        res.status = ST_OVER;
                    end else begin
                        shadow_stack[shadow_depth] = item.immediate;
                        shadow_depth++;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (shadow_depth < 2) begin
                        res.status = ST_UNDER;
                    end else begin
                        top_w  = shadow_stack[shadow_depth - 1];
                        next_w = shadow_stack[shadow_depth - 2];
                        case (item.op)
                            OP_ADD: result_w = next_w + top_w;
                            OP_SUB: result_w = next_w - top_w;
                            OP_MUL: result_w = next_w * top_w;
                            default: begin
                                if (top_w == '0) begin
                                    res.status = ST_DIVZ;
                                end else begin
                                    // magnitudes keep MIN / -1 wrapping to MIN
                                    mag_n = next_w[DATA_W-1] ? -next_w : next_w;
                                    mag_d = top_w[DATA_W-1] ? -top_w : top_w;
                                    quot  = mag_n / mag_d;
                                    result_w = (next_w[DATA_W-1] ^ top_w[DATA_W-1]) ?
                                               -quot : quot;
                                end
                            end
                        endcase
                        if (res.status == ST_OK) begin
                            shadow_stack[shadow_depth - 2] = result_w;
                            shadow_depth--;
                        end
                    end
                end
                OP_POP: begin
                    if (shadow_depth == 0) begin
                        res.status = ST_UNDER;
                    end else begin
                        res.value = shadow_stack[shadow_depth - 1];
                        popped = 1'b1;
                        shadow_depth--;
                    end
                end
                OP_HALT: shadow_halted = 1'b1;
                default: ;
            endcase
        end
        if (!popped) begin
            res.value = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth - 1];
        end
        res.depth  = shadow_depth[DEPTH_W-1:0];
        res.halted = shadow_halted;
        return res;
    endfunction

    // drives one item, waits for acceptance and records its expected result
    task automatic send_item(input logic [2:0] code, input logic [DATA_W-1:0] imm);
        sme_in_t     item;
        int unsigned gap;
        item.op        = code;
        item.immediate = imm;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pending_results.push_back(execute_op(item));
    endtask

    // sender holds off until every outstanding result has come back
    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [2:0] random_reducing_op();
        case ($urandom_range(0, 9))
            0, 1: return OP_ADD;
            2, 3: return OP_SUB;
            4, 5: return OP_MUL;
            6, 7: return OP_DIV;
            default: return OP_POP;
        endcase
    endfunction

    // result side stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        sme_out_t exp_res;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result status %0d value %h depth %0d halted %b",
                             m_data.status, m_data.value, m_data.depth, m_data.halted);
            end else begin
                exp_res = pending_results.pop_front();
                if (m_data.status !== exp_res.status || m_data.value !== exp_res.value ||
                    m_data.depth !== exp_res.depth || m_data.halted !== exp_res.halted) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $write("ERROR: result mismatch at cycle %0d: expected status %0d ",
                               cycle_count, exp_res.status);
                        $write("value %h depth %0d halted %b, ",
                               exp_res.value, exp_res.depth, exp_res.halted);
                        $display("got status %0d value %h depth %0d halted %b",
                                 m_data.status, m_data.value, m_data.depth, m_data.halted);
                    end
                end
            end
        end
    end

    // wraparound, truncation, divide by zero, underflow and the unused code
    task automatic test_directed_ops();
        send_item(OP_PUSH, MAX_WORD);
        send_item(OP_PUSH, 32'd1);
        send_item(OP_ADD, random_word());       // wraps to MIN
        send_item(OP_PUSH, 32'd1);
        send_item(OP_SUB, random_word());       // wraps back to MAX
        send_item(OP_PUSH, MAX_WORD);
        send_item(OP_MUL, random_word());       // MAX * MAX = 1
        send_item(OP_PUSH, '0);
        send_item(OP_DIV, random_word());       // divide by zero, no change
        send_item(OP_POP, random_word());
        send_item(OP_POP, random_word());
        send_item(OP_POP, random_word());       // empty
        send_item(OP_ADD, random_word());       // empty
        send_item(OP_PUSH, MIN_WORD);
        send_item(OP_DIV, random_word());       // one entry
        send_item(OP_PUSH, ALL_ONES);
        send_item(OP_DIV, random_word());       // MIN / -1
        send_item(OP_PUSH, 32'd7);
        send_item(OP_PUSH, ~32'd1);
        send_item(OP_DIV, random_word());       // 7 / -2 truncates to -3
        send_item(OP_SUB, random_word());
        send_item(OP_UNUSED, random_word());
        send_item(OP_POP, random_word());
    endtask

    // fill to the top, push past it, then drain
    task automatic test_stack_full();
        while (shadow_depth < STACK_DEPTH) send_item(OP_PUSH, random_word());
        repeat (3) send_item(OP_PUSH, random_word());
        while (shadow_depth > 0) send_item(random_reducing_op(), random_word());
    endtask

    // mostly well-formed programs around a moving depth target, some noise
    task automatic test_random_program();
        int unsigned target;
        int unsigned r;
        logic [2:0]  code;
        target = 8;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
                target  = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250) :
                          $urandom_range(2, 40);
            end
            if (i == RANDOM_ITEMS / 2) wait_results();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                code = 3'($urandom_range(0, 7));
                if (code == OP_HALT) code = OP_POP;     // halt is kept for the end
            end else if (shadow_depth < 2 || (shadow_depth < target && r < 60)) begin
                code = OP_PUSH;
            end else begin
                code = random_reducing_op();
            end
            send_item(code, random_word());
        end
    endtask

    // halt reports ok, everything after it is refused
    task automatic test_halt();
        send_item(OP_HALT, random_word());
        for (int i = 0; i < 20; i++) send_item(3'($urandom_range(0, 7)), random_word());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;
        test_directed_ops();
        wait_results();
        test_stack_full();
        wait_results();
        test_random_program();
        wait_results();
        idle_on = 1'b1;
        test_halt();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
